@@ rtl/lcs_pkg.sv @@
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types and constants of the character display command sequencer.
// ----------------------------------------------------------------------------
package lcs_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned CFG_W       = 16;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned ROWS_W      = 40;
	localparam int unsigned STEP_W      = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_SETTLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_SETTLE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP     = 2'd2;

	localparam logic [CFG_W-1:0] SHORT_SETTLE_RST = 16'd50;
	localparam logic [CFG_W-1:0] LONG_SETTLE_RST  = 16'd2000;
	localparam logic [CFG_W-1:0] POWER_UP_RST     = 16'd20000;

	// display command bytes
	localparam logic [7:0] CMD_FUNC_SET  = 8'h38;
	localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
	localparam logic [7:0] CMD_CLEAR     = 8'h01;
	localparam logic [7:0] CMD_ENTRY     = 8'h06;
	localparam logic [7:0] CMD_HOME      = 8'h02;
	localparam logic [7:0] CMD_SHIFT_L   = 8'h10;
	localparam logic [7:0] CMD_SHIFT_R   = 8'h14;
	localparam logic [7:0] CMD_DDRAM     = 8'h80;
	localparam logic [7:0] CMD_CGRAM     = 8'h40;
	localparam logic [7:0] CTRL_RST      = 8'h0C;
	localparam logic [7:0] CTRL_CURSOR   = 8'h02;
	localparam logic [7:0] CTRL_BLINK    = 8'h01;

	localparam logic RS_CMD  = 1'b0;
	localparam logic RS_DATA = 1'b1;

	// sequence positions
	localparam logic [STEP_W-1:0] INIT_LAST  = 4'd4;
	localparam logic [STEP_W-1:0] GLYPH_LAST = 4'd9;

	typedef enum logic [2:0] {
		REQ_INIT    = 3'd0,
		REQ_PUT     = 3'd1,
		REQ_VISIBLE = 3'd2,
		REQ_BLINK   = 3'd3,
		REQ_LEFT    = 3'd4,
		REQ_RIGHT   = 3'd5,
		REQ_GOTO    = 3'd6,
		REQ_GLYPH   = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		JOB_ONE   = 2'd0,
		JOB_INIT  = 2'd1,
		JOB_GLYPH = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t         kind;
		logic              rs;
		logic [7:0]        cmd_byte;
		logic [ROWS_W-1:0] rows;
	} job_t;

endpackage

@@ rtl/lcs_front.sv @@
// ----------------------------------------------------------------------------
// lcs_front
// Takes requests, keeps the display-control byte and turns each request
// into a compact job word for the write sequencer.
// ----------------------------------------------------------------------------
module lcs_front import lcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              q_full,
	input  logic [2:0]        req_type,
	input  logic [7:0]        char_code,
	input  logic              flag_on,
	input  logic              row_sel,
	input  logic [3:0]        col_sel,
	input  logic [2:0]        glyph_slot,
	input  logic [ROWS_W-1:0] glyph_rows,
	output logic              job_wr,
	output job_t              job
);

	logic [7:0] disp_ctrl_q;
	logic [7:0] disp_ctrl_next;

	assign job_wr = push && !q_full;

	always_comb begin
		disp_ctrl_next = disp_ctrl_q;
		job.kind       = JOB_ONE;
		job.rs         = RS_CMD;
		job.cmd_byte   = disp_ctrl_q;
		job.rows       = glyph_rows;
		unique case (req_t'(req_type))
			REQ_INIT: begin
				job.kind = JOB_INIT;
			end
			REQ_PUT: begin
				job.rs       = RS_DATA;
				job.cmd_byte = char_code;
			end
			REQ_VISIBLE: begin
				disp_ctrl_next = flag_on ? (disp_ctrl_q | CTRL_CURSOR)
				                         : (disp_ctrl_q & ~CTRL_CURSOR);
				job.cmd_byte = disp_ctrl_next;
			end
			REQ_BLINK: begin
				disp_ctrl_next = flag_on ? (disp_ctrl_q | CTRL_BLINK)
				                         : (disp_ctrl_q & ~CTRL_BLINK);
				job.cmd_byte = disp_ctrl_next;
			end
			REQ_LEFT: begin
				job.cmd_byte = CMD_SHIFT_L;
			end
			REQ_RIGHT: begin
				job.cmd_byte = CMD_SHIFT_R;
			end
			REQ_GOTO: begin
				// bottom row base is 0x40; column never carries into it
				job.cmd_byte = CMD_DDRAM | {1'b0, row_sel, 2'b00, col_sel};
			end
			REQ_GLYPH: begin
				job.kind     = JOB_GLYPH;
				job.cmd_byte = CMD_CGRAM | {2'b00, glyph_slot, 3'b000};
			end
			default: begin
				job.kind = JOB_ONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_ctrl_q <= CTRL_RST;
		end else if (job_wr) begin
			disp_ctrl_q <= disp_ctrl_next;
		end
	end

endmodule

@@ rtl/lcs_queue.sv @@
// ----------------------------------------------------------------------------
// lcs_queue
// Small job queue between the request front and the write sequencer.
// ----------------------------------------------------------------------------
module lcs_queue import lcs_pkg::*; #(
	parameter int unsigned Depth = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_data,
	input  logic rd_en,
	output job_t rd_data,
	output logic full,
	output logic empty
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(Depth);

	job_t            slots_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_wr;
	logic            do_rd;

	assign full    = (count_q == CntFull);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/lcs_back.sv @@
// ----------------------------------------------------------------------------
// lcs_back
// Write sequencer: walks each job one bus write per cycle while the output
// is free or popped, adds lead and settle delays and registers the result.
// ----------------------------------------------------------------------------
module lcs_back import lcs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  job_t                 job,
	input  logic                 job_empty,
	output logic                 job_rd,
	input  logic                 pop,
	output logic                 empty,
	output logic                 reg_select,
	output logic [7:0]           bus_byte,
	output logic [CFG_W-1:0]     lead_wait_us,
	output logic [CFG_W-1:0]     settle_wait_us,
	output logic                 last_write
);

	logic [CFG_W-1:0]  short_settle_q;
	logic [CFG_W-1:0]  long_settle_q;
	logic [CFG_W-1:0]  power_up_q;
	logic [STEP_W-1:0] step_q;

	logic              out_v_q;
	logic              rs_q;
	logic [7:0]        byte_q;
	logic [CFG_W-1:0]  lead_q;
	logic [CFG_W-1:0]  settle_q;
	logic              last_q;

	logic              load;
	logic              advance;
	logic              w_rs;
	logic [7:0]        w_byte;
	logic [CFG_W-1:0]  w_lead;
	logic [CFG_W-1:0]  w_settle;
	logic              w_last;
	logic [2:0]        row_idx;

	assign load    = !out_v_q || pop;
	assign advance = load && !job_empty;
	assign job_rd  = advance && w_last;
	assign row_idx = 3'(step_q - 1'b1);

	always_comb begin
		w_rs   = RS_CMD;
		w_byte = job.cmd_byte;
		w_lead = '0;
		w_last = 1'b1;
		unique case (job.kind)
			JOB_INIT: begin
				w_last = (step_q == INIT_LAST);
				case (step_q)
					4'd0: begin
						w_byte = CMD_FUNC_SET;
						w_lead = power_up_q;
					end
					4'd1:    w_byte = CMD_DISP_OFF;
					4'd2:    w_byte = CMD_CLEAR;
					4'd3:    w_byte = CMD_ENTRY;
					default: w_byte = job.cmd_byte;
				endcase
			end
			JOB_GLYPH: begin
				w_last = (step_q == GLYPH_LAST);
				if (step_q == GLYPH_LAST) begin
					w_byte = CMD_DDRAM;
				end else if (step_q != '0) begin
					w_rs   = RS_DATA;
					w_byte = {3'b000, job.rows[5*row_idx +: 5]};
				end
			end
			default: begin
				w_rs = job.rs;
			end
		endcase
		// clear and home need the long settle time
		w_settle = (w_rs == RS_CMD && (w_byte == CMD_CLEAR || w_byte == CMD_HOME))
		           ? long_settle_q : short_settle_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_settle_q <= SHORT_SETTLE_RST;
			long_settle_q  <= LONG_SETTLE_RST;
			power_up_q     <= POWER_UP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SHORT_SETTLE: short_settle_q <= cfg_data;
				CFG_LONG_SETTLE:  long_settle_q  <= cfg_data;
				CFG_POWER_UP:     power_up_q     <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				out_v_q <= !job_empty;
			end
			if (advance) begin
				step_q <= w_last ? '0 : step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rs_q     <= w_rs;
			byte_q   <= w_byte;
			lead_q   <= w_lead;
			settle_q <= w_settle;
			last_q   <= w_last;
		end
	end

	assign empty          = !out_v_q;
	assign reg_select     = rs_q;
	assign bus_byte       = byte_q;
	assign lead_wait_us   = lead_q;
	assign settle_wait_us = settle_q;
	assign last_write     = last_q;

endmodule

@@ rtl/char_lcd_command_sequencer_unit.sv @@
// A request goes through the job queue, then the output register, to the result ports.
// The sequencer emits one bus write per cycle unless a result word waits unpopped:
// init is 5 writes, define glyph 10, others 1; that write loop sets the sustained rate.
// The job queue holds QueueDepth requests, so requests keep coming while writes drain.
// Asynchronous active-low reset empties the queue and output register and restores
// the display-control byte and the delay registers to their defaults.
// ----------------------------------------------------------------------------
// char_lcd_command_sequencer_unit
// Turns character display requests into 8-bit bus writes with delays.
// ----------------------------------------------------------------------------
module char_lcd_command_sequencer_unit import lcs_pkg::*; #(
	parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 push,
	output logic                 full,
	input  logic [2:0]           req_type,
	input  logic [7:0]           char_code,
	input  logic                 flag_on,
	input  logic                 row_sel,
	input  logic [3:0]           col_sel,
	input  logic [2:0]           glyph_slot,
	input  logic [ROWS_W-1:0]    glyph_rows,
	output logic                 empty,
	input  logic                 pop,
	output logic                 reg_select,
	output logic [7:0]           bus_byte,
	output logic [CFG_W-1:0]     lead_wait_us,
	output logic [CFG_W-1:0]     settle_wait_us,
	output logic                 last_write
);

	job_t wr_job;
	job_t rd_job;
	logic job_wr;
	logic job_rd;
	logic q_empty;

	lcs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.q_full     (full),
		.req_type   (req_type),
		.char_code  (char_code),
		.flag_on    (flag_on),
		.row_sel    (row_sel),
		.col_sel    (col_sel),
		.glyph_slot (glyph_slot),
		.glyph_rows (glyph_rows),
		.job_wr     (job_wr),
		.job        (wr_job)
	);

	lcs_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_wr),
		.wr_data (wr_job),
		.rd_en   (job_rd),
		.rd_data (rd_job),
		.full    (full),
		.empty   (q_empty)
	);

	lcs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.job            (rd_job),
		.job_empty      (q_empty),
		.job_rd         (job_rd),
		.pop            (pop),
		.empty          (empty),
		.reg_select     (reg_select),
		.bus_byte       (bus_byte),
		.lead_wait_us   (lead_wait_us),
		.settle_wait_us (settle_wait_us),
		.last_write     (last_write)
	);

endmodule

@@ rtl/lcs_checker.sv @@
// ----------------------------------------------------------------------------
// lcs_checker
// Port-level checks of the command sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lcs_checker import lcs_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 empty,
	input logic                 pop,
	input logic                 reg_select,
	input logic [7:0]           bus_byte,
	input logic [CFG_W-1:0]     lead_wait_us,
	input logic [CFG_W-1:0]     settle_wait_us,
	input logic                 last_write
);

	// nothing to show while reset is held
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result word present during reset");

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(bus_byte) && $stable(reg_select)
		                   && $stable(last_write) && $stable(lead_wait_us)
		                   && $stable(settle_wait_us))
		else $error("stalled result word changed");

	// only the opening function-set write of init carries a lead delay
	a_lead_first: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && lead_wait_us != '0 |-> reg_select == RS_CMD
		                               && bus_byte == CMD_FUNC_SET && !last_write)
		else $error("lead delay on a write other than the first init write");

	// the function-set write of init is always followed by display off
	a_init_order: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && lead_wait_us != '0 |=> empty || (bus_byte == CMD_DISP_OFF
		                                        && reg_select == RS_CMD)
		                                        || (bus_byte == CMD_FUNC_SET))
		else $error("init sequence out of order");

endmodule

bind char_lcd_command_sequencer_unit lcs_checker u_lcs_checker (.*);
